// ===== src/mhpq_pkg.sv =====
// ============================================================================
// mhpq_pkg: shared types and constants of the min-heap priority queue
// Operation codes, fixed field widths and the control and status bundles
// exchanged between the sequencer and the level cells.
// ============================================================================
package mhpq_pkg;

	localparam int NODE_W   = 8;
	localparam int REQ_W    = 31;
	localparam int COUNT_W  = 9;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 56;

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_POP      = 2'd1,
		OP_UPDATE   = 2'd2,
		OP_CONTAINS = 2'd3
	} op_t;

	typedef struct packed {
		logic rd_en;
		logic wr_lo;
		logic wr_hi;
		logic scan_start;
	} cell_ctl_t;

	typedef struct packed {
		logic done;
		logic hit;
	} cell_sts_t;

endpackage

// ===== src/mhpq_cell.sv =====
// ============================================================================
// mhpq_cell: storage and search cell for one heap level
// Holds the entries of one tree level as rows of sibling pairs, serves
// row reads and single-entry writes, and scans its rows for a node id.
// ============================================================================
module mhpq_cell #(
	parameter int LEVEL   = 0,
	parameter int LEVELS  = 9,
	parameter int ENTRY_W = 39
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  mhpq_pkg::cell_ctl_t                     ctl,
	input  logic [((LEVELS > 2) ? LEVELS-2 : 1)-1:0] rd_row,
	input  logic [((LEVELS > 2) ? LEVELS-2 : 1)-1:0] wr_row,
	input  logic [ENTRY_W-1:0]                      wr_data,
	input  logic [mhpq_pkg::NODE_W-1:0]             scan_node,
	input  logic [LEVELS-1:0]                       count,
	output logic [ENTRY_W-1:0]                      rd_e0,
	output logic [ENTRY_W-1:0]                      rd_e1,
	output mhpq_pkg::cell_sts_t                     sts,
	output logic [LEVELS-2:0]                       hit_off
);
	import mhpq_pkg::*;

	localparam int ROWS  = (LEVEL == 0) ? 1 : (1 << (LEVEL - 1));
	localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W = LEVELS + 1;
	localparam int OFF_W = LEVELS - 1;
	localparam int BASE  = (1 << LEVEL) - 1;
	localparam int PRI_W = ENTRY_W - NODE_W;

	logic [ENTRY_W-1:0] mem0 [ROWS];
	logic [ENTRY_W-1:0] mem1 [ROWS];

	logic            scan_busy_q;
	logic [RA_W-1:0] scan_row_q;
	logic            chk_s1;
	logic [RA_W-1:0] chk_row_s1;
	logic            done_q;
	logic            hit_q;
	logic [OFF_W-1:0] hit_off_q;

	logic [RA_W-1:0]  ra;
	logic [IDX_W-1:0] idx0;
	logic [IDX_W-1:0] idx1;
	logic             m0;
	logic             m1;
	logic             last_row;
	logic             scan_hit;

	assign ra = scan_busy_q ? scan_row_q : rd_row[RA_W-1:0];

	assign idx0 = IDX_W'(BASE) + (IDX_W'(chk_row_s1) << 1);
	assign idx1 = idx0 + IDX_W'(1);
	assign m0 = (rd_e0[ENTRY_W-1:PRI_W] == scan_node) && (idx0 < IDX_W'(count));
	assign m1 = (LEVEL != 0) && (rd_e1[ENTRY_W-1:PRI_W] == scan_node)
		&& (idx1 < IDX_W'(count));
	assign last_row = (chk_row_s1 == RA_W'(ROWS - 1));
	assign scan_hit = chk_s1 && !done_q && (m0 || m1);

	always_ff @(posedge clk) begin
		if (ctl.wr_lo) begin
			mem0[wr_row[RA_W-1:0]] <= wr_data;
		end
		if (ctl.wr_hi) begin
			mem1[wr_row[RA_W-1:0]] <= wr_data;
		end
		if (ctl.rd_en || scan_busy_q) begin
			rd_e0 <= mem0[ra];
			rd_e1 <= mem1[ra];
		end
		chk_row_s1 <= scan_row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_busy_q <= 1'b0;
			scan_row_q  <= '0;
			chk_s1      <= 1'b0;
			done_q      <= 1'b1;
			hit_q       <= 1'b0;
			hit_off_q   <= '0;
		end else if (ctl.scan_start) begin
			scan_busy_q <= 1'b1;
			scan_row_q  <= '0;
			chk_s1      <= 1'b0;
			done_q      <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			chk_s1 <= scan_busy_q;
			if (scan_busy_q) begin
				if ((scan_row_q == RA_W'(ROWS - 1)) || scan_hit) begin
					scan_busy_q <= 1'b0;
				end else begin
					scan_row_q <= scan_row_q + RA_W'(1);
				end
			end
			if (scan_hit) begin
				done_q <= 1'b1;
				hit_q  <= 1'b1;
				if (LEVEL == 0) begin
					hit_off_q <= '0;
				end else begin
					hit_off_q <= OFF_W'({chk_row_s1, !m0});
				end
			end else if (chk_s1 && !done_q && last_row) begin
				done_q <= 1'b1;
			end
		end
	end

	assign sts.done = done_q;
	assign sts.hit  = hit_q;
	assign hit_off  = hit_off_q;

endmodule

// ===== src/min_heap_priority_queue.sv =====
// ============================================================================
// min_heap_priority_queue: binary min-heap of (node id, priority) entries
// Insert, pop-min, update-priority and contains, one result per operation.
// ============================================================================
// The heap is a chain of level cells, one per tree level, each with its own
// pair-wide memory; a sequencer walks the moving entry between neighboring
// cells, one level at a time (read, then compare and write). Update and
// contains first search all cells in parallel, one row of two entries per
// cycle; the bottom cell's single read port over its CAPACITY/2 rows bounds
// the search, and update then adds a sift. A new operation is taken while
// the previous result still waits on the output.
// ============================================================================
module min_heap_priority_queue #(
	parameter int CAPACITY      = 256,
	parameter int PRIORITY_BITS = 31
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// node_id[7:0], priority_req[38:8], zero pad
	input  logic [mhpq_pkg::S_DATA_W-1:0]   s_axis_tdata,
	// op[1:0]
	input  logic [1:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// popped_node[7:0], popped_valid[8], min_priority[39:9], heap_empty[40],
	// entry_count[49:41], found[50], overflow[51], zero pad
	output logic [mhpq_pkg::M_DATA_W-1:0]   m_axis_tdata
);
	import mhpq_pkg::*;

	localparam int LEVELS  = $clog2(CAPACITY + 1);
	localparam int LV_W    = $clog2(LEVELS);
	localparam int TLV_W   = $clog2(LEVELS + 1);
	localparam int OFF_W   = LEVELS - 1;
	localparam int ROW_W   = (LEVELS > 2) ? LEVELS - 2 : 1;
	localparam int IDX_W   = LEVELS + 1;
	localparam int CNT_W   = LEVELS;
	localparam int PRI_W   = PRIORITY_BITS;
	localparam int ENTRY_W = NODE_W + PRI_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN_GO, ST_SCAN_WAIT, ST_UPD_RD, ST_UPD_CMP,
		ST_UP_RD, ST_UP_CMP, ST_DN_RD, ST_DN_CMP, ST_POP_RD, ST_POP_GOT,
		ST_LAST_RD, ST_LAST_GOT, ST_ROOT_RD, ST_ROOT_GOT, ST_DONE
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [NODE_W-1:0] node_q;
	logic [PRI_W-1:0]  prio_q;
	logic [NODE_W-1:0] cur_node_q;
	logic [PRI_W-1:0]  cur_prio_q;
	logic [LV_W-1:0]   lv_q;
	logic [OFF_W-1:0]  off_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TLV_W-1:0]  tail_lv_q;
	logic [OFF_W-1:0]  tail_off_q;
	logic [NODE_W-1:0] popped_node_q;
	logic              popped_valid_q;
	logic              found_q;
	logic              overflow_q;
	logic [PRI_W-1:0]  minp_q;

	cell_ctl_t          ctl     [LEVELS];
	cell_sts_t          sts     [LEVELS];
	logic [ENTRY_W-1:0] rd0     [LEVELS];
	logic [ENTRY_W-1:0] rd1     [LEVELS];
	logic [OFF_W-1:0]   hit_off [LEVELS];

	logic               rd_req;
	logic [LV_W-1:0]    rd_lv;
	logic [ROW_W-1:0]   rd_row;
	logic               wr_req;
	logic [LV_W-1:0]    wr_lv;
	logic [OFF_W-1:0]   wr_off;
	logic [ENTRY_W-1:0] wr_data;
	logic               scan_go;

	logic [LV_W-1:0]    plv;
	logic [LV_W-1:0]    clv;
	logic [OFF_W-1:0]   poff;
	logic [IDX_W-1:0]   cidx;
	logic [ENTRY_W-1:0] par_e;
	logic [ENTRY_W-1:0] le;
	logic [ENTRY_W-1:0] re;
	logic [ENTRY_W-1:0] sel_e;
	logic [ENTRY_W-1:0] tail_e;
	logic               r_ok;
	logic               dn_stop;
	logic               dn_move;
	logic               dn_right;
	logic               all_done;
	logic               any_hit;
	logic [LV_W-1:0]    hit_lv;
	logic [OFF_W-1:0]   hit_o;
	logic [PRI_W-1:0]   prio_in;
	logic [OFF_W-1:0]   tail_max;
	logic [OFF_W-1:0]   tail_pmax;

	assign prio_in = PRI_W'(s_axis_tdata[38:8]);

	assign plv  = lv_q - LV_W'(1);
	assign clv  = lv_q + LV_W'(1);
	assign poff = off_q >> 1;
	assign cidx = (IDX_W'(2) << lv_q) - IDX_W'(1) + (IDX_W'(off_q) << 1);
	assign par_e  = poff[0] ? rd1[plv] : rd0[plv];
	assign le     = rd0[clv];
	assign re     = rd1[clv];
	assign sel_e  = off_q[0] ? rd1[lv_q] : rd0[lv_q];
	assign tail_e = tail_off_q[0] ? rd1[LV_W'(tail_lv_q)] : rd0[LV_W'(tail_lv_q)];
	assign r_ok    = (cidx + IDX_W'(1)) < IDX_W'(cnt_q);
	assign dn_stop = (lv_q == LV_W'(LEVELS - 1)) || (cidx >= IDX_W'(cnt_q));
	assign tail_max  = (OFF_W'(1) << tail_lv_q) - OFF_W'(1);
	assign tail_pmax = (OFF_W'(1) << (tail_lv_q - TLV_W'(1))) - OFF_W'(1);

	always_comb begin
		dn_right = 1'b0;
		if (!r_ok) begin
			dn_move = cur_prio_q > le[PRI_W-1:0];
		end else begin
			dn_right = !(le[PRI_W-1:0] < re[PRI_W-1:0]);
			dn_move  = dn_right ? !(cur_prio_q < re[PRI_W-1:0])
				: !(cur_prio_q < le[PRI_W-1:0]);
		end
	end

	always_comb begin
		all_done = 1'b1;
		any_hit  = 1'b0;
		hit_lv   = '0;
		hit_o    = '0;
		for (int k = LEVELS - 1; k >= 0; k--) begin
			all_done = all_done & sts[k].done;
			if (sts[k].hit) begin
				any_hit = 1'b1;
				hit_lv  = LV_W'(k);
				hit_o   = hit_off[k];
			end
		end
	end

	always_comb begin
		rd_req  = 1'b0;
		rd_lv   = '0;
		rd_row  = '0;
		wr_req  = 1'b0;
		wr_lv   = lv_q;
		wr_off  = off_q;
		wr_data = {cur_node_q, cur_prio_q};
		scan_go = 1'b0;
		unique case (state_q)
			ST_SCAN_GO: scan_go = 1'b1;
			ST_UPD_RD: begin
				rd_req = 1'b1;
				rd_lv  = lv_q;
				rd_row = ROW_W'(off_q >> 1);
			end
			ST_UPD_CMP: begin
				if (sel_e[PRI_W-1:0] == prio_q) begin
					wr_req  = 1'b1;
					wr_data = {node_q, prio_q};
				end
			end
			ST_UP_RD: begin
				if (lv_q == '0) begin
					wr_req = 1'b1;
				end else begin
					rd_req = 1'b1;
					rd_lv  = plv;
					rd_row = ROW_W'(poff >> 1);
				end
			end
			ST_UP_CMP: begin
				wr_req = 1'b1;
				if (cur_prio_q < par_e[PRI_W-1:0]) begin
					wr_data = par_e;
				end
			end
			ST_DN_RD: begin
				if (dn_stop) begin
					wr_req = 1'b1;
				end else begin
					rd_req = 1'b1;
					rd_lv  = clv;
					rd_row = ROW_W'(off_q);
				end
			end
			ST_DN_CMP: begin
				wr_req = 1'b1;
				if (dn_move) begin
					wr_data = dn_right ? re : le;
				end
			end
			ST_POP_RD, ST_ROOT_RD: rd_req = 1'b1;
			ST_LAST_RD: begin
				rd_req = 1'b1;
				rd_lv  = LV_W'(tail_lv_q);
				rd_row = ROW_W'(tail_off_q >> 1);
			end
			default: ;
		endcase
	end

	for (genvar k = 0; k < LEVELS; k++) begin : g_cell
		assign ctl[k].rd_en      = rd_req && (rd_lv == LV_W'(k));
		assign ctl[k].wr_lo      = wr_req && (wr_lv == LV_W'(k)) && !wr_off[0];
		assign ctl[k].wr_hi      = wr_req && (wr_lv == LV_W'(k)) && wr_off[0];
		assign ctl[k].scan_start = scan_go;

		mhpq_cell #(
			.LEVEL   (k),
			.LEVELS  (LEVELS),
			.ENTRY_W (ENTRY_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[k]),
			.rd_row    (rd_row),
			.wr_row    (ROW_W'(wr_off >> 1)),
			.wr_data   (wr_data),
			.scan_node (node_q),
			.count     (cnt_q),
			.rd_e0     (rd0[k]),
			.rd_e1     (rd1[k]),
			.sts       (sts[k]),
			.hit_off   (hit_off[k])
		);
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			op_q           <= OP_INSERT;
			node_q         <= '0;
			prio_q         <= '0;
			cur_node_q     <= '0;
			cur_prio_q     <= '0;
			lv_q           <= '0;
			off_q          <= '0;
			cnt_q          <= '0;
			tail_lv_q      <= '0;
			tail_off_q     <= '0;
			popped_node_q  <= '0;
			popped_valid_q <= 1'b0;
			found_q        <= 1'b0;
			overflow_q     <= 1'b0;
			minp_q         <= '0;
			m_axis_tvalid  <= 1'b0;
			m_axis_tdata   <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && (state_q != ST_DONE)) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						op_q           <= op_t'(s_axis_tuser);
						node_q         <= s_axis_tdata[7:0];
						prio_q         <= prio_in;
						popped_node_q  <= '0;
						popped_valid_q <= 1'b0;
						found_q        <= 1'b0;
						overflow_q     <= (op_t'(s_axis_tuser) == OP_INSERT)
							&& (cnt_q == CNT_W'(CAPACITY));
						unique case (op_t'(s_axis_tuser))
							OP_INSERT: begin
								if (cnt_q == CNT_W'(CAPACITY)) begin
									state_q <= ST_ROOT_RD;
								end else begin
									cur_node_q <= s_axis_tdata[7:0];
									cur_prio_q <= prio_in;
									lv_q       <= LV_W'(tail_lv_q);
									off_q      <= tail_off_q;
									cnt_q      <= cnt_q + CNT_W'(1);
									if (tail_off_q == tail_max) begin
										tail_lv_q  <= tail_lv_q + TLV_W'(1);
										tail_off_q <= '0;
									end else begin
										tail_off_q <= tail_off_q + OFF_W'(1);
									end
									state_q <= ST_UP_RD;
								end
							end
							OP_POP: begin
								state_q <= (cnt_q == '0) ? ST_ROOT_RD : ST_POP_RD;
							end
							OP_UPDATE, OP_CONTAINS: state_q <= ST_SCAN_GO;
						endcase
					end
				end
				ST_SCAN_GO: state_q <= ST_SCAN_WAIT;
				ST_SCAN_WAIT: begin
					if (all_done) begin
						found_q <= any_hit;
						lv_q    <= hit_lv;
						off_q   <= hit_o;
						if (any_hit && (op_q == OP_UPDATE)) begin
							state_q <= ST_UPD_RD;
						end else begin
							state_q <= ST_ROOT_RD;
						end
					end
				end
				ST_UPD_RD: state_q <= ST_UPD_CMP;
				ST_UPD_CMP: begin
					cur_node_q <= node_q;
					cur_prio_q <= prio_q;
					priority if (sel_e[PRI_W-1:0] > prio_q) begin
						state_q <= ST_UP_RD;
					end else if (sel_e[PRI_W-1:0] < prio_q) begin
						state_q <= ST_DN_RD;
					end else begin
						state_q <= ST_ROOT_RD;
					end
				end
				ST_UP_RD: state_q <= (lv_q == '0) ? ST_ROOT_RD : ST_UP_CMP;
				ST_UP_CMP: begin
					if (cur_prio_q < par_e[PRI_W-1:0]) begin
						lv_q    <= plv;
						off_q   <= poff;
						state_q <= ST_UP_RD;
					end else begin
						state_q <= ST_ROOT_RD;
					end
				end
				ST_DN_RD: state_q <= dn_stop ? ST_ROOT_RD : ST_DN_CMP;
				ST_DN_CMP: begin
					if (dn_move) begin
						lv_q    <= clv;
						off_q   <= {off_q[OFF_W-2:0], dn_right};
						state_q <= ST_DN_RD;
					end else begin
						state_q <= ST_ROOT_RD;
					end
				end
				ST_POP_RD: state_q <= ST_POP_GOT;
				ST_POP_GOT: begin
					popped_node_q  <= rd0[0][ENTRY_W-1:PRI_W];
					popped_valid_q <= 1'b1;
					cnt_q          <= cnt_q - CNT_W'(1);
					if (tail_off_q == '0) begin
						tail_lv_q  <= tail_lv_q - TLV_W'(1);
						tail_off_q <= tail_pmax;
					end else begin
						tail_off_q <= tail_off_q - OFF_W'(1);
					end
					state_q <= (cnt_q == CNT_W'(1)) ? ST_ROOT_RD : ST_LAST_RD;
				end
				ST_LAST_RD: state_q <= ST_LAST_GOT;
				ST_LAST_GOT: begin
					cur_node_q <= tail_e[ENTRY_W-1:PRI_W];
					cur_prio_q <= tail_e[PRI_W-1:0];
					lv_q       <= '0;
					off_q      <= '0;
					state_q    <= ST_DN_RD;
				end
				ST_ROOT_RD: state_q <= ST_ROOT_GOT;
				ST_ROOT_GOT: begin
					minp_q  <= (cnt_q == '0) ? '0 : rd0[0][PRI_W-1:0];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= {4'd0, overflow_q, found_q, COUNT_W'(cnt_q),
							(cnt_q == '0), REQ_W'(minp_q), popped_valid_q, popped_node_q};
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// ============================================================================
// tb_top: testbench of the min-heap priority queue
// Drives insert, pop, update and contains transfers. A scoreboard keeps its
// own copy of the heap, predicts every result, and checks each result
// transfer field by field against the oldest prediction.
// ============================================================================
class heap_scoreboard;
	typedef struct packed {
		logic [7:0]  popped_node;
		logic        popped_valid;
		logic [30:0] min_priority;
		logic        heap_empty;
		logic [8:0]  entry_count;
		logic        found;
		logic        overflow;
	} heap_result_t;

	logic [7:0]   node_arr[256];
	logic [30:0]  prio_arr[256];
	int           count;
	heap_result_t pending[$];
	int           errors;

	function new();
		count = 0;
		errors = 0;
	endfunction

	function void swap_pos(int a, int b);
		logic [7:0]  n;
		logic [30:0] p;
		n = node_arr[a]; p = prio_arr[a];
		node_arr[a] = node_arr[b]; prio_arr[a] = prio_arr[b];
		node_arr[b] = n; prio_arr[b] = p;
	endfunction

	function void bubble_up(int i);
		int par;
		while (i > 0 && i < count) begin
			par = (i - 1) / 2;
			if (prio_arr[i] < prio_arr[par]) begin
				swap_pos(i, par);
				i = par;
			end else begin
				break;
			end
		end
	endfunction

	function void bubble_down(int i);
		int l;
		int r;
		int c;
		while (i < count) begin
			l = 2 * i + 1;
			r = l + 1;
			if (l >= count) break;
			if (r >= count) begin
				if (prio_arr[i] > prio_arr[l]) begin
					swap_pos(i, l);
					i = l;
				end else begin
					break;
				end
			end else begin
				if (prio_arr[i] < prio_arr[l] && prio_arr[i] < prio_arr[r]) break;
				c = (prio_arr[l] < prio_arr[r]) ? l : r;
				swap_pos(i, c);
				i = c;
			end
		end
	endfunction

	function int locate(logic [7:0] node);
		for (int i = 0; i < count; i++)
			if (node_arr[i] == node) return i;
		return -1;
	endfunction

	function void note_op(mhpq_pkg::op_t op, logic [7:0] node, logic [30:0] prio);
		heap_result_t res;
		int pos;
		logic [30:0] old;
		res = '0;
		case (op)
			mhpq_pkg::OP_INSERT: begin
				if (count >= 256) begin
					res.overflow = 1'b1;
				end else begin
					node_arr[count] = node;
					prio_arr[count] = prio;
					count++;
					bubble_up(count - 1);
				end
			end
			mhpq_pkg::OP_POP: begin
				if (count > 0) begin
					res.popped_node = node_arr[0];
					res.popped_valid = 1'b1;
					count--;
					if (count > 0) begin
						node_arr[0] = node_arr[count];
						prio_arr[0] = prio_arr[count];
						bubble_down(0);
					end
				end
			end
			mhpq_pkg::OP_UPDATE: begin
				pos = locate(node);
				if (pos >= 0) begin
					res.found = 1'b1;
					old = prio_arr[pos];
					prio_arr[pos] = prio;
					if (old > prio) bubble_up(pos);
					else if (old < prio) bubble_down(pos);
				end
			end
			default: res.found = (locate(node) >= 0);
		endcase
		res.min_priority = (count > 0) ? prio_arr[0] : '0;
		res.heap_empty = (count == 0);
		res.entry_count = count[8:0];
		pending.insert(pending.size(), res);
	endfunction

	task report(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	task check_result(logic [55:0] data);
		heap_result_t exp;
		heap_result_t got;
		got = {data[7:0], data[8], data[39:9], data[40], data[49:41], data[50], data[51]};
		if (pending.size() == 0) begin
			report("result with nothing expected");
			return;
		end
		exp = pending.pop_front();
		if (got.popped_node !== exp.popped_node)
			report($sformatf("popped_node %0d exp %0d", got.popped_node, exp.popped_node));
		if (got.popped_valid !== exp.popped_valid)
			report($sformatf("popped_valid %0b exp %0b", got.popped_valid, exp.popped_valid));
		if (got.min_priority !== exp.min_priority)
			report($sformatf("min_priority %0d exp %0d", got.min_priority, exp.min_priority));
		if (got.heap_empty !== exp.heap_empty)
			report($sformatf("heap_empty %0b exp %0b", got.heap_empty, exp.heap_empty));
		if (got.entry_count !== exp.entry_count)
			report($sformatf("entry_count %0d exp %0d", got.entry_count, exp.entry_count));
		if (got.found !== exp.found)
			report($sformatf("found %0b exp %0b", got.found, exp.found));
		if (got.overflow !== exp.overflow)
			report($sformatf("overflow %0b exp %0b", got.overflow, exp.overflow));
	endtask
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mhpq_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata;
	logic [1:0]          s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [M_DATA_W-1:0] m_axis_tdata;

	heap_scoreboard sb;
	int  cycles = 0;
	bit  quiet_tail;
	bit  hold_sink;
	int  live_count;
	logic [7:0] used_ids[$];

	min_heap_priority_queue u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[min_heap_priority_queue] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// result-side ready: random stalls, one long hold-off
	initial begin
		int n;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				m_axis_tready <= 1'b0;
				for (int i = 0; i < 400; i++) @(negedge clk);
				hold_sink = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 10);
				m_axis_tready <= 1'b0;
				for (int i = 1; i < n; i++) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task send(op_t op, logic [7:0] node, logic [30:0] prio);
		int n;
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 10);
			s_axis_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {1'b0, prio, node};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_op(op, node, prio);
		if (op == OP_INSERT && live_count < 256) begin
			live_count++;
			used_ids.insert(used_ids.size(), node);
		end else if (op == OP_POP && live_count > 0) begin
			live_count--;
		end
		@(negedge clk);
	endtask

	function logic [30:0] rand_prio();
		case ($urandom_range(0, 3))
			0: return 31'($urandom_range(0, 15));
			1: return 31'h7fff_fff0 + 31'($urandom_range(0, 15));
			default: return 31'($urandom());
		endcase
	endfunction

	function logic [7:0] rand_id();
		if (used_ids.size() > 0 && $urandom_range(0, 2) != 0)
			return used_ids[$urandom_range(0, used_ids.size() - 1)];
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		int k;
		int r;
		sb = new();
		quiet_tail = 1'b0;
		hold_sink = 1'b0;
		live_count = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_INSERT;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty cases, extremes, ties, absent node, same priority
		send(OP_POP, 8'd0, 31'd0);
		send(OP_CONTAINS, 8'd5, 31'd0);
		send(OP_UPDATE, 8'd5, 31'd3);
		send(OP_INSERT, 8'd255, 31'h7fff_ffff);
		send(OP_INSERT, 8'd0, 31'd0);
		send(OP_INSERT, 8'd7, 31'd100);
		send(OP_INSERT, 8'd7, 31'd100);
		send(OP_INSERT, 8'd9, 31'd100);
		send(OP_CONTAINS, 8'd7, 31'd0);
		send(OP_CONTAINS, 8'd200, 31'd0);
		send(OP_UPDATE, 8'd7, 31'd100);
		send(OP_UPDATE, 8'd255, 31'd1);
		send(OP_UPDATE, 8'd0, 31'h7fff_ffff);
		send(OP_UPDATE, 8'd42, 31'd1);
		send(OP_INSERT, 8'hAA, 31'h2aaa_aaaa);
		send(OP_INSERT, 8'h55, 31'h5555_5555);
		repeat (8) send(OP_POP, 8'd0, 31'd0);

		// fill to capacity, overflow, with the sink held off early on
		hold_sink = 1'b1;
		while (live_count < 256) send(OP_INSERT, 8'($urandom_range(0, 255)), rand_prio());
		send(OP_INSERT, 8'd1, 31'd1);
		send(OP_INSERT, 8'd2, 31'd2);
		for (k = 0; k < 40; k++) send(k[0] ? OP_UPDATE : OP_CONTAINS, rand_id(), rand_prio());
		while (live_count > 0) send(OP_POP, 8'd0, 31'd0);
		send(OP_POP, 8'd0, 31'd0);
		used_ids.delete();

		// random mix biased to keep a moderately sized heap
		for (k = 0; k < 270; k++) begin
			if (k == 220) quiet_tail = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 40 && live_count < 256)
				send(OP_INSERT, rand_id(), rand_prio());
			else if (r < 65)
				send(OP_POP, rand_id(), rand_prio());
			else if (r < 85)
				send(OP_UPDATE, rand_id(), rand_prio());
			else
				send(OP_CONTAINS, rand_id(), rand_prio());
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("[min_heap_priority_queue] OK");
		else
			$display("[min_heap_priority_queue] ERROR");
		$finish;
	end
endmodule
